// ----- hw/rtl/rc4_stream_cipher_assert.svh -----
// ----------------------------------------------------------------------------
// RC4 stream cipher assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// Condition holds at every edge.
`define RC4_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RC4_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RC4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// RC4 package
// Shared types, constants and sequencer states of the RC4 stream cipher.
// ----------------------------------------------------------------------------
package rc4_pkg;

    localparam int KEY_DEPTH = 256;
    localparam int KEY_AW    = $clog2(KEY_DEPTH);
    localparam int KEY_CW    = KEY_AW + 1;
    localparam logic [KEY_CW-1:0] KEY_LIMIT = KEY_CW'(KEY_DEPTH);

    localparam int PERM_DEPTH = 256;
    localparam logic [7:0] BYTE_MAX = 8'hff;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_D_RD_I,
        ST_D_RD_J,
        ST_D_RD_T,
        ST_D_WR_I,
        ST_K_RD_N,
        ST_K_RD_J,
        ST_K_WR_J,
        ST_K_WR_N
    } rc4_state_t;

    typedef struct packed {
        logic       valid;
        logic       opcode;
        logic [7:0] data;
        logic       last;
    } rc4_req_t;

    typedef struct packed {
        logic       busy;
        logic       valid;
        logic [7:0] data;
    } rc4_rsp_t;

endpackage

// ----- hw/rtl/rc4_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Key loading, key schedule and byte-wise encryption with a registered output.
//
//  Channel  Handshake             Payload
//  input    in_valid / in_ready   opcode, data_in, last_key_byte
//  output   out_valid / out_ready data_out
//
// Reset: an identity sweep of the permutation memory, in_ready low.
// Key byte: taken in idle. Last key byte: identity sweep plus 256
// rounds of two reads and two writes on the permutation memory.
// Data byte: three reads and two writes on that memory.
// A result waiting in the output register stalls only the next data byte.
// ----------------------------------------------------------------------------
module rc4_stream_cipher
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [7:0] data_in,
    input  logic       last_key_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_out
);

    rc4_pkg::rc4_req_t req;
    rc4_pkg::rc4_rsp_t rsp;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] data_out_reg, data_out_next;
    logic       out_free;

    assign in_ready   = !rsp.busy;
    assign req.valid  = in_valid && in_ready;
    assign req.opcode = opcode;
    assign req.data   = data_in;
    assign req.last   = last_key_byte;
    assign out_free   = !out_valid_reg || out_ready;

    rc4_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .rsp      (rsp)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        data_out_next  = data_out_reg;
        priority if (rsp.valid)
        begin
            out_valid_next = 1'b1;
            data_out_next  = rsp.data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_out_reg <= data_out_next;
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;

endmodule

// ----- hw/rtl/rc4_core.sv -----
// ----------------------------------------------------------------------------
// RC4 core
// Sequencer over the permutation and key memories: identity sweep, key
// schedule and per-byte keystream generation.
// ----------------------------------------------------------------------------
`include "rc4_stream_cipher_assert.svh"

module rc4_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  rc4_pkg::rc4_req_t req,
    input  logic              out_free,
    output rc4_pkg::rc4_rsp_t rsp
);

    rc4_pkg::rc4_state_t state_reg, state_next;

    logic [7:0]                n_reg, n_next;
    logic                      sched_reg, sched_next;
    logic [7:0]                i_reg, i_next;
    logic [7:0]                j_reg, j_next;
    logic [7:0]                ti_reg, ti_next;
    logic [7:0]                tj_reg, tj_next;
    logic [7:0]                data_reg, data_next;
    logic [rc4_pkg::KEY_CW-1:0] k_reg, k_next;
    logic [rc4_pkg::KEY_CW-1:0] key_len_reg, key_len_next;
    logic [rc4_pkg::KEY_CW-1:0] key_count_reg, key_count_next;

    logic [7:0] s_mem [rc4_pkg::PERM_DEPTH];
    logic [7:0] s_rdata_reg;
    logic [7:0] s_raddr;
    logic       s_we;
    logic [7:0] s_waddr;
    logic [7:0] s_wdata;

    logic [7:0]                k_mem [rc4_pkg::KEY_DEPTH];
    logic [7:0]                k_rdata_reg;
    logic [rc4_pkg::KEY_AW-1:0] k_raddr;
    logic                      k_we;

    logic                      key_store;
    logic [rc4_pkg::KEY_CW-1:0] key_count_inc;
    logic [rc4_pkg::KEY_CW-1:0] k_inc;
    logic [7:0]                t_addr;
    logic [7:0]                ks;
    logic [7:0]                ksa_j;

    assign key_store     = (key_count_reg < rc4_pkg::KEY_LIMIT);
    assign key_count_inc = key_count_reg + rc4_pkg::KEY_CW'(key_store);
    assign k_inc         = k_reg + rc4_pkg::KEY_CW'(1);
    assign t_addr        = ti_reg + tj_reg;
    assign ksa_j         = j_reg + s_rdata_reg + k_rdata_reg;
    assign k_we          = req.valid && (req.opcode == rc4_pkg::OP_KEY) && key_store;
    assign k_raddr       = k_reg[rc4_pkg::KEY_AW-1:0];

    always_comb
    begin
        priority if (t_addr == i_reg)
        begin
            ks = tj_reg;
        end
        else if (t_addr == j_reg)
        begin
            ks = ti_reg;
        end
        else
        begin
            ks = s_rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            s_mem[s_waddr] <= s_wdata;
        end
        s_rdata_reg <= s_mem[s_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (k_we)
        begin
            k_mem[key_count_reg[rc4_pkg::KEY_AW-1:0]] <= req.data;
        end
        k_rdata_reg <= k_mem[k_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4_pkg::ST_INIT;
            n_reg         <= '0;
            sched_reg     <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            key_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            sched_reg     <= sched_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            key_count_reg <= key_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ti_reg      <= ti_next;
        tj_reg      <= tj_next;
        data_reg    <= data_next;
        k_reg       <= k_next;
        key_len_reg <= key_len_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        sched_next     = sched_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        ti_next        = ti_reg;
        tj_next        = tj_reg;
        data_next      = data_reg;
        k_next         = k_reg;
        key_len_next   = key_len_reg;
        key_count_next = key_count_reg;
        s_raddr        = '0;
        s_we           = 1'b0;
        s_waddr        = '0;
        s_wdata        = '0;
        rsp.busy       = (state_reg != rc4_pkg::ST_IDLE);
        rsp.valid      = 1'b0;
        rsp.data       = data_reg ^ ks;

        unique case (state_reg)
            rc4_pkg::ST_INIT:
            begin
                s_we    = 1'b1;
                s_waddr = n_reg;
                s_wdata = n_reg;
                n_next  = n_reg + 8'd1;
                if (n_reg == rc4_pkg::BYTE_MAX)
                begin
                    state_next = sched_reg ? rc4_pkg::ST_K_RD_N : rc4_pkg::ST_IDLE;
                    sched_next = 1'b0;
                end
            end

            rc4_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.opcode == rc4_pkg::OP_DATA)
                    begin
                        data_next  = req.data;
                        state_next = rc4_pkg::ST_D_RD_I;
                    end
                    else if (req.last)
                    begin
                        key_len_next   = (key_count_inc == '0) ?
                                         rc4_pkg::KEY_CW'(1) : key_count_inc;
                        key_count_next = '0;
                        k_next         = '0;
                        i_next         = '0;
                        j_next         = '0;
                        n_next         = '0;
                        sched_next     = 1'b1;
                        state_next     = rc4_pkg::ST_INIT;
                    end
                    else
                    begin
                        key_count_next = key_count_inc;
                    end
                end
            end

            rc4_pkg::ST_D_RD_I:
            begin
                s_raddr    = i_reg + 8'd1;
                i_next     = i_reg + 8'd1;
                state_next = rc4_pkg::ST_D_RD_J;
            end

            rc4_pkg::ST_D_RD_J:
            begin
                ti_next    = s_rdata_reg;
                j_next     = j_reg + s_rdata_reg;
                s_raddr    = j_reg + s_rdata_reg;
                state_next = rc4_pkg::ST_D_RD_T;
            end

            rc4_pkg::ST_D_RD_T:
            begin
                tj_next    = s_rdata_reg;
                s_we       = 1'b1;
                s_waddr    = j_reg;
                s_wdata    = ti_reg;
                s_raddr    = ti_reg + s_rdata_reg;
                state_next = rc4_pkg::ST_D_WR_I;
            end

            rc4_pkg::ST_D_WR_I:
            begin
                // hold the keystream address while the output is stalled
                s_raddr = t_addr;
                s_we    = 1'b1;
                s_waddr = i_reg;
                s_wdata = tj_reg;
                if (out_free)
                begin
                    rsp.valid  = 1'b1;
                    state_next = rc4_pkg::ST_IDLE;
                end
            end

            rc4_pkg::ST_K_RD_N:
            begin
                s_raddr    = n_reg;
                state_next = rc4_pkg::ST_K_RD_J;
            end

            rc4_pkg::ST_K_RD_J:
            begin
                ti_next    = s_rdata_reg;
                j_next     = ksa_j;
                s_raddr    = ksa_j;
                state_next = rc4_pkg::ST_K_WR_J;
            end

            rc4_pkg::ST_K_WR_J:
            begin
                tj_next    = s_rdata_reg;
                s_we       = 1'b1;
                s_waddr    = j_reg;
                s_wdata    = ti_reg;
                state_next = rc4_pkg::ST_K_WR_N;
            end

            rc4_pkg::ST_K_WR_N:
            begin
                s_we    = 1'b1;
                s_waddr = n_reg;
                s_wdata = tj_reg;
                n_next  = n_reg + 8'd1;
                k_next  = (k_inc >= key_len_reg) ? '0 : k_inc;
                if (n_reg == rc4_pkg::BYTE_MAX)
                begin
                    j_next     = '0;
                    state_next = rc4_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rc4_pkg::ST_K_RD_N;
                end
            end

            default:
            begin
                state_next = rc4_pkg::ST_IDLE;
            end
        endcase
    end

    `RC4_ASSERT_IMPLIES(a_req_in_idle, req.valid, state_reg == rc4_pkg::ST_IDLE, "request outside idle")
    `RC4_ASSERT_HOLDS(a_key_count_max, key_count_reg <= rc4_pkg::KEY_LIMIT, "key count overflow")
    `RC4_ASSERT_IMPLIES(a_key_index, (state_reg == rc4_pkg::ST_K_RD_N) || (state_reg == rc4_pkg::ST_K_WR_N), k_reg < key_len_reg, "key index past key length")
    `RC4_ASSERT_NEXT(a_result_idle, rsp.valid, state_reg == rc4_pkg::ST_IDLE, "no return to idle after result")

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Loads keys of many lengths, runs the key schedule and streams data bytes
// through the cipher. A scoreboard tracks the permutation, the indices and
// the pending key, and checks every output byte in order. Both channels idle
// at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned TARGET_ITEMS = 1200;
    localparam int unsigned DRAIN_CYCLES = 1500;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_STARVED
    } rx_mode_t;

    class rc4_cipher_tracker;
        logic [7:0]  perm [rc4_pkg::PERM_DEPTH];
        logic [7:0]  key_bytes [rc4_pkg::KEY_DEPTH];
        int unsigned key_len;
        logic [7:0]  idx_i;
        logic [7:0]  idx_j;
        logic [7:0]  expected_bytes [$];
        int unsigned mismatches;

        function new();
            for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++)
            begin
                perm[n] = 8'(n);
            end
            for (int n = 0; n < rc4_pkg::KEY_DEPTH; n++)
            begin
                key_bytes[n] = 8'h00;
            end
            key_len    = 0;
            idx_i      = 8'h00;
            idx_j      = 8'h00;
            mismatches = 0;
        endfunction

        function void schedule_key();
            int unsigned len;
            int unsigned k;
            logic [7:0]  j;
            logic [7:0]  t;
            len = (key_len == 0) ? 1 : key_len;
            for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++)
            begin
                perm[n] = 8'(n);
            end
            j = 8'h00;
            k = 0;
            for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++)
            begin
                t       = perm[n];
                j       = j + t + key_bytes[k];
                perm[n] = perm[j];
                perm[j] = t;
                k++;
                if (k >= len)
                    k = 0;
            end
            idx_i   = 8'h00;
            idx_j   = 8'h00;
            key_len = 0;
        endfunction

        // Returns 1 when the transaction changes state or produces a byte.
        function bit accept_item(logic op, logic [7:0] din, logic last);
            logic [7:0] ti;
            logic [7:0] tj;
            bit         effective;
            effective = 1'b1;
            if (op == rc4_pkg::OP_KEY)
            begin
                if (key_len < rc4_pkg::KEY_DEPTH)
                begin
                    key_bytes[key_len] = din;
                    key_len++;
                end
                else
                begin
                    effective = last;
                end
                if (last)
                    schedule_key();
            end
            else
            begin
                idx_i       = idx_i + 8'd1;
                ti          = perm[idx_i];
                idx_j       = idx_j + ti;
                tj          = perm[idx_j];
                perm[idx_j] = ti;
                perm[idx_i] = tj;
                expected_bytes.push_back(din ^ perm[8'(ti + tj)]);
            end
            return effective;
        endfunction

        function void check_byte(logic [7:0] actual);
            logic [7:0] expected;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: data_out %02h with no byte expected", $time, actual);
                mismatches++;
            end
            else
            begin
                expected = expected_bytes.pop_front();
                if (actual !== expected)
                begin
                    $display("%0t: data_out expected %02h actual %02h",
                             $time, expected, actual);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       opcode;
    logic [7:0] data_in;
    logic       last_key_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] data_out;

    rc4_cipher_tracker tracker;
    int unsigned       effective_items = 0;
    int unsigned       burst_left      = 0;
    int unsigned       cycle_count     = 0;
    int unsigned       rx_phase_left   = 0;
    rx_mode_t          rx_mode         = RX_OPEN;

    rc4_stream_cipher uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .data_in       (data_in),
        .last_key_byte (last_key_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_out      (data_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_mode       = rx_mode_t'($urandom_range(0, 2));
            rx_phase_left = $urandom_range(16, 200);
        end
        else
        begin
            rx_phase_left--;
        end
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
            default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_byte(data_out);
    end

    task automatic send_item(input logic op, input logic [7:0] din, input logic last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        in_valid      <= 1'b1;
        opcode        <= op;
        data_in       <= din;
        last_key_byte <= last;
        do
            @(posedge clk);
        while (!in_ready);
        if (tracker.accept_item(op, din, last))
            effective_items++;
    endtask

    // Load a key of len bytes, marking the final one; optionally slip data
    // bytes into the partial load.
    task automatic load_key(input int unsigned len, input bit mix_data);
        for (int unsigned n = 0; n < len; n++)
        begin
            if (mix_data && $urandom_range(0, 7) == 0)
                send_item(rc4_pkg::OP_DATA, 8'($urandom), 1'($urandom_range(0, 1)));
            send_item(rc4_pkg::OP_KEY, 8'($urandom), n == len - 1);
        end
    endtask

    task automatic stream_data(input int unsigned count);
        repeat (count)
        begin
            send_item(rc4_pkg::OP_DATA, 8'($urandom), ($urandom_range(0, 15) == 0));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = rc4_pkg::OP_KEY;
        data_in       = 8'h00;
        last_key_byte = 1'b0;
        out_ready     = 1'b0;
        tracker       = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // identity permutation before any key
        send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
        send_item(rc4_pkg::OP_DATA, 8'hff, 1'b1);
        send_item(rc4_pkg::OP_DATA, 8'h5a, 1'b0);
        // data in the middle of a partial key load
        send_item(rc4_pkg::OP_KEY, 8'h00, 1'b0);
        send_item(rc4_pkg::OP_KEY, 8'hff, 1'b0);
        send_item(rc4_pkg::OP_DATA, 8'h3c, 1'b0);
        send_item(rc4_pkg::OP_KEY, 8'h80, 1'b1);
        send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
        send_item(rc4_pkg::OP_DATA, 8'hff, 1'b0);
        send_item(rc4_pkg::OP_DATA, 8'h55, 1'b1);
        send_item(rc4_pkg::OP_DATA, 8'haa, 1'b0);
        // a fresh single-byte key after the schedule
        send_item(rc4_pkg::OP_KEY, 8'h01, 1'b1);
        send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
        send_item(rc4_pkg::OP_DATA, 8'hff, 1'b0);
        send_item(rc4_pkg::OP_DATA, 8'h81, 1'b0);
        send_item(rc4_pkg::OP_KEY, 8'hff, 1'b0);
        send_item(rc4_pkg::OP_KEY, 8'h7f, 1'b0);
        send_item(rc4_pkg::OP_KEY, 8'hfe, 1'b1);
        send_item(rc4_pkg::OP_DATA, 8'h01, 1'b0);
        send_item(rc4_pkg::OP_DATA, 8'h80, 1'b0);

        // key too long, last mark on a dropped byte, then a full-depth key
        load_key(rc4_pkg::KEY_DEPTH + 2, 1'b0);
        stream_data(20);
        load_key(rc4_pkg::KEY_DEPTH, 1'b0);
        stream_data(20);

        while (effective_items < TARGET_ITEMS)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                if ($urandom_range(0, 19) == 0)
                    load_key($urandom_range(17, 64), $urandom_range(0, 4) == 0);
                else
                    load_key($urandom_range(1, 16), $urandom_range(0, 4) == 0);
                stream_data($urandom_range(8, 48));
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                begin
                    send_item($urandom_range(0, 1) ? rc4_pkg::OP_DATA : rc4_pkg::OP_KEY,
                              8'($urandom), ($urandom_range(0, 3) == 0));
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.expected_bytes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_core.sv
hw/rtl/rc4_stream_cipher.sv
bench/testbench.sv
